@@ src/drd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package drd_pkg;

  // field widths
  localparam int unsigned VecW  = 16;
  localparam int unsigned IorW  = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 3;

  // register byte address bit that selects the register
  localparam int unsigned RegSelBit = 2;

  localparam logic [IorW-1:0] IorOuterRst = 16'd4096;
  localparam logic [IorW-1:0] IorInnerRst = 16'd6144;

  typedef enum logic {
    REG_IOR_OUTER = 1'b0,
    REG_IOR_INNER = 1'b1
  } reg_idx_e;

  // pipeline depth per section
  localparam int unsigned Div1Steps = 21;
  localparam int unsigned Sq1Steps  = 28;
  localparam int unsigned NormSteps = 6;
  localparam int unsigned Sq2Steps  = 31;
  localparam int unsigned Div2Steps = 15;
  localparam int unsigned NumStages = 3 + Div1Steps + 4 + Sq1Steps + 4 + NormSteps + 2
                                      + Sq2Steps + 1 + Div2Steps + 1;

endpackage

`default_nettype wire

@@ src/drd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface drd_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [drd_pkg::VecW-1:0] inc_x;
  logic signed [drd_pkg::VecW-1:0] inc_y;
  logic signed [drd_pkg::VecW-1:0] inc_z;
  logic signed [drd_pkg::VecW-1:0] norm_x;
  logic signed [drd_pkg::VecW-1:0] norm_y;
  logic signed [drd_pkg::VecW-1:0] norm_z;

  modport source (output valid, inc_x, inc_y, inc_z, norm_x, norm_y, norm_z, input ready);
  modport sink (input valid, inc_x, inc_y, inc_z, norm_x, norm_y, norm_z, output ready);
endinterface

interface drd_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [drd_pkg::VecW-1:0] out_x;
  logic signed [drd_pkg::VecW-1:0] out_y;
  logic signed [drd_pkg::VecW-1:0] out_z;
  logic signed [drd_pkg::VecW-1:0] cos_refracted;
  logic                             total_reflection;

  modport source (output valid, out_x, out_y, out_z, cos_refracted, total_reflection,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, cos_refracted, total_reflection,
                output ready);
endinterface

`default_nettype wire

@@ src/dielectric_refraction_direction.sv @@
// Refracts a unit incident direction through a dielectric boundary with the given unit normal
// (Snell's law) and returns the normalized refracted direction, the signed refracted cosine and
// a total internal reflection flag. One item enters per clock unless the output stalls. The
// pipeline contains the pipelined index-ratio divider (21 stages), the two bit-per-stage square
// roots (28 and 31 stages), a 6-stage normalize shifter and the 15-stage per-component divider
// of the final normalization. The whole pipeline holds while a result waits on the output, so
// no item is ever dropped. Index registers sit at byte addresses 0 (outer) and 4 (inner), Q4.12,
// and are meant to be written while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module dielectric_refraction_direction (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  drd_in_if.sink                        in_i,
  drd_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [drd_pkg::AddrW-1:0]     paddr,
  input  logic [drd_pkg::DataW-1:0]     pwdata,
  output logic [drd_pkg::DataW-1:0]     prdata,
  output logic                          pready
);

  localparam int unsigned Nst = drd_pkg::NumStages;
  localparam int unsigned EStage = 3 + drd_pkg::Div1Steps;
  localparam int unsigned Mw = 53;
  localparam logic [20:0] RatioMax = 21'h100000;

  typedef struct packed {
    logic [36:0]      rem;
    logic [20:0]      q;
    logic [15:0]      den;
    logic             ovf;
    logic             neg;
    logic [31:0]      d;
    logic [32:0]      dd;
    logic [2:0][15:0] iv;
    logic [2:0][15:0] nv;
  } div1_t;

  typedef struct packed {
    logic [54:0]      rem;
    logic [27:0]      root;
    logic             tir;
    logic             neg;
    logic [37:0]      rd;
    logic [2:0][37:0] ir;
    logic [2:0][15:0] nv;
  } sq1_t;

  typedef struct packed {
    logic [Mw-1:0]        mx;
    logic [2:0][Mw-1:0]   mag;
    logic [2:0]           sgn;
    logic                 zero;
    logic                 tir;
    logic [15:0]          cos;
  } nrm_t;

  typedef struct packed {
    logic [61:0]      rem;
    logic [30:0]      root;
    logic [2:0][29:0] m;
    logic [2:0]       sgn;
    logic             zero;
    logic             tir;
    logic [15:0]      cos;
  } sq2_t;

  typedef struct packed {
    logic [2:0][44:0] rem;
    logic [2:0][14:0] q;
    logic [30:0]      len;
    logic [2:0]       sgn;
    logic             zero;
    logic             tir;
    logic [15:0]      cos;
  } div2_t;

  // configuration registers
  logic [15:0] ior_outer_q, ior_inner_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ior_outer_q <= drd_pkg::IorOuterRst;
      ior_inner_q <= drd_pkg::IorInnerRst;
    end else if (psel && penable && pwrite) begin
      case (drd_pkg::reg_idx_e'(paddr[drd_pkg::RegSelBit]))
        drd_pkg::REG_IOR_OUTER: ior_outer_q <= pwdata[15:0];
        drd_pkg::REG_IOR_INNER: ior_inner_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (drd_pkg::reg_idx_e'(paddr[drd_pkg::RegSelBit]))
      drd_pkg::REG_IOR_OUTER: prdata = {16'b0, ior_outer_q};
      drd_pkg::REG_IOR_INNER: prdata = {16'b0, ior_inner_q};
      default:                prdata = '0;
    endcase
  end

  // flow control: the whole pipe moves unless the output holds an untaken item
  logic [Nst-1:0] vld_q;
  logic           adv;

  assign adv        = !vld_q[Nst-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Nst-2:0], in_i.valid};
    end
  end

  // stage a: products of the dot product
  logic [2:0][15:0]  in_iv, in_nv;
  logic signed [31:0] s1_p [3];
  logic [2:0][15:0]  a_iv_q, a_nv_q;
  logic [2:0][31:0]  a_p_q;

  assign in_iv = {in_i.inc_z, in_i.inc_y, in_i.inc_x};
  assign in_nv = {in_i.norm_z, in_i.norm_y, in_i.norm_x};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s1_p[k] = $signed(in_iv[k]) * $signed(in_nv[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_iv_q <= in_iv;
      a_nv_q <= in_nv;
      for (int k = 0; k < 3; k++) begin
        a_p_q[k] <= s1_p[k];
      end
    end
  end

  // stage b: sum and clamp to [-4, 4]
  logic signed [32:0] s2_sum;
  logic signed [31:0] s2_d;
  logic signed [31:0] b_d_q;
  logic [2:0][15:0]  b_iv_q, b_nv_q;

  always_comb begin
    s2_sum = $signed(a_p_q[0]) + $signed(a_p_q[1]) + $signed(a_p_q[2]);
    if (s2_sum > 33'sd1073741824) begin
      s2_d = 32'sd1073741824;
    end else if (s2_sum < -33'sd1073741824) begin
      s2_d = -32'sd1073741824;
    end else begin
      s2_d = s2_sum[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_d_q  <= s2_d;
      b_iv_q <= a_iv_q;
      b_nv_q <= a_nv_q;
    end
  end

  // stage c: side select, d squared, divider setup
  logic               s3_neg;
  logic signed [31:0] s3_negd;
  logic [30:0]        s3_dmag;
  logic [61:0]        s3_dd2;
  logic [15:0]        s3_num, s3_den;
  div1_t              s3;
  div1_t              dv1_q [drd_pkg::Div1Steps+1];

  always_comb begin
    s3_neg  = b_d_q[31];
    s3_negd = -b_d_q;
    s3_dmag = s3_neg ? s3_negd[30:0] : b_d_q[30:0];
    s3_dd2  = s3_dmag * s3_dmag;
    s3_num  = s3_neg ? ior_inner_q : ior_outer_q;
    s3_den  = s3_neg ? ior_outer_q : ior_inner_q;
    if (s3_den == '0) begin
      s3_den = 16'd1;
    end
    s3.rem = {5'b0, s3_num, 16'b0};
    s3.q   = '0;
    s3.den = s3_den;
    s3.ovf = {5'b0, s3_num} >= {s3_den, 5'b0};
    s3.neg = s3_neg;
    s3.d   = b_d_q;
    s3.dd  = s3_dd2[60:28];
    s3.iv  = b_iv_q;
    s3.nv  = b_nv_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv1_q[0] <= s3;
    end
  end

  // index ratio divider, one quotient bit per stage
  for (genvar j = 1; j <= drd_pkg::Div1Steps; j++) begin : g_div1
    localparam int unsigned Sh = drd_pkg::Div1Steps - j;
    logic [36:0] trial;
    div1_t       nxt;
    always_comb begin
      nxt   = dv1_q[j-1];
      trial = 37'(dv1_q[j-1].den) << Sh;
      if (dv1_q[j-1].rem >= trial) begin
        nxt.rem   = dv1_q[j-1].rem - trial;
        nxt.q[Sh] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv1_q[j] <= nxt;
      end
    end
  end

  // stage e: clamp ratio, 1 - d*d
  div1_t              s4;
  logic [20:0]        s4_r16;
  logic [20:0]        e_r16_q;
  logic signed [33:0] e_om_q;
  logic signed [31:0] e_d_q;
  logic               e_neg_q;
  logic [2:0][15:0]  e_iv_q, e_nv_q;

  always_comb begin
    s4 = dv1_q[drd_pkg::Div1Steps];
    if (s4.ovf || s4.q > RatioMax) begin
      s4_r16 = RatioMax;
    end else begin
      s4_r16 = s4.q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_r16_q <= s4_r16;
      e_om_q  <= 34'sd268435456 - $signed({1'b0, s4.dd});
      e_d_q   <= $signed(s4.d);
      e_neg_q <= s4.neg;
      e_iv_q  <= s4.iv;
      e_nv_q  <= s4.nv;
    end
  end

  // stage f: r*r, r*d, r*incident
  logic [41:0]        s5_rr;
  logic signed [53:0] s5_rdp;
  logic signed [37:0] s5_ir [3];
  logic [24:0]        f_r2_q;
  logic signed [53:0] f_rdp_q;
  logic [2:0][37:0]  f_ir_q;
  logic signed [33:0] f_om_q;
  logic               f_neg_q;
  logic [2:0][15:0]  f_nv_q;

  always_comb begin
    s5_rr  = e_r16_q * e_r16_q;
    s5_rdp = $signed({1'b0, e_r16_q}) * e_d_q;
    for (int k = 0; k < 3; k++) begin
      s5_ir[k] = $signed({1'b0, e_r16_q}) * $signed(e_iv_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_r2_q  <= s5_rr[40:16];
      f_rdp_q <= s5_rdp;
      for (int k = 0; k < 3; k++) begin
        f_ir_q[k] <= s5_ir[k];
      end
      f_om_q  <= e_om_q;
      f_neg_q <= e_neg_q;
      f_nv_q  <= e_nv_q;
    end
  end

  // stage g: r2 * (1 - d*d)
  logic signed [59:0] s6_pr;
  logic signed [59:0] g_pr_q;
  logic [37:0]        g_rd_q;
  logic [2:0][37:0]  g_ir_q;
  logic               g_neg_q;
  logic [2:0][15:0]  g_nv_q;

  assign s6_pr = $signed({1'b0, f_r2_q}) * f_om_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_pr_q  <= s6_pr;
      g_rd_q  <= f_rdp_q[53:16];
      g_ir_q  <= f_ir_q;
      g_neg_q <= f_neg_q;
      g_nv_q  <= f_nv_q;
    end
  end

  // stage h: cos^2 of the refracted ray, reflection test
  logic signed [44:0] s7_s;
  logic               s7_tir;
  sq1_t               s7;
  sq1_t               sq1_q [drd_pkg::Sq1Steps+1];

  always_comb begin
    s7_s     = 45'sd268435456 - $signed(g_pr_q[59:16]);
    s7_tir   = s7_s[44] || (s7_s == '0);
    s7.rem   = s7_tir ? '0 : {s7_s[40:0], 14'b0};
    s7.root  = '0;
    s7.tir   = s7_tir;
    s7.neg   = g_neg_q;
    s7.rd    = g_rd_q;
    s7.ir    = g_ir_q;
    s7.nv    = g_nv_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq1_q[0] <= s7;
    end
  end

  for (genvar j = 1; j <= drd_pkg::Sq1Steps; j++) begin : g_sq1
    localparam int unsigned Bi = drd_pkg::Sq1Steps - j;
    logic [56:0] trial;
    sq1_t        nxt;
    always_comb begin
      nxt   = sq1_q[j-1];
      trial = (57'(sq1_q[j-1].root) << (Bi + 1)) + (57'(1) << (2 * Bi));
      if ({2'b0, sq1_q[j-1].rem} >= trial) begin
        nxt.rem      = sq1_q[j-1].rem - trial[54:0];
        nxt.root[Bi] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq1_q[j] <= nxt;
      end
    end
  end

  // stage i: refracted cosine and normal factor
  sq1_t               s8;
  logic [28:0]        s8_rnd;
  logic [21:0]        s8_c14;
  logic [15:0]        s8_cpos, s8_cos;
  logic signed [37:0] s8_root28;
  logic signed [37:0] s8_nf;
  logic signed [37:0] i_nf_q;
  logic [15:0]        i_cos_q;
  logic               i_tir_q;
  logic [2:0][37:0]  i_ir_q;
  logic [2:0][15:0]  i_nv_q;

  always_comb begin
    s8        = sq1_q[drd_pkg::Sq1Steps];
    s8_rnd    = {1'b0, s8.root} + 29'd64;
    s8_c14    = s8_rnd[28:7];
    s8_cpos   = (s8_c14 > 22'd16384) ? 16'd16384 : s8_c14[15:0];
    if (s8.tir) begin
      s8_cos = '0;
    end else begin
      s8_cos = s8.neg ? s8_cpos : 16'd0 - s8_cpos;
    end
    s8_root28 = $signed({3'b0, s8.root, 7'b0});
    s8_nf     = s8.neg ? $signed(s8.rd) + s8_root28 : $signed(s8.rd) - s8_root28;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      i_nf_q  <= s8_nf;
      i_cos_q <= s8_cos;
      i_tir_q <= s8.tir;
      i_ir_q  <= s8.ir;
      i_nv_q  <= s8.nv;
    end
  end

  // stage j: normal times factor
  logic signed [53:0] s9_pn [3];
  logic [2:0][53:0]  j_pn_q;
  logic [2:0][37:0]  j_ir_q;
  logic [15:0]        j_cos_q;
  logic               j_tir_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s9_pn[k] = $signed(i_nv_q[k]) * i_nf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        j_pn_q[k] <= s9_pn[k];
      end
      j_ir_q  <= i_ir_q;
      j_cos_q <= i_cos_q;
      j_tir_q <= i_tir_q;
    end
  end

  // stage l: unnormalized direction, sign and magnitude
  logic signed [54:0] s10_v [3];
  logic signed [54:0] s10_nv [3];
  logic [2:0][Mw-1:0] l_mag_q;
  logic [2:0]         l_sgn_q;
  logic [15:0]        l_cos_q;
  logic               l_tir_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s10_v[k]  = $signed(j_pn_q[k]) - ($signed(j_ir_q[k]) <<< 12);
      s10_nv[k] = -s10_v[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        l_mag_q[k] <= s10_v[k][54] ? s10_nv[k][Mw-1:0] : s10_v[k][Mw-1:0];
        l_sgn_q[k] <= s10_v[k][54];
      end
      l_cos_q <= j_cos_q;
      l_tir_q <= j_tir_q;
    end
  end

  // stage: largest magnitude
  logic [Mw-1:0] s11_m01;
  nrm_t          s11;
  nrm_t          nrm_q [drd_pkg::NormSteps+1];

  always_comb begin
    s11_m01  = (l_mag_q[0] > l_mag_q[1]) ? l_mag_q[0] : l_mag_q[1];
    s11.mx   = (s11_m01 > l_mag_q[2]) ? s11_m01 : l_mag_q[2];
    s11.mag  = l_mag_q;
    s11.sgn  = l_sgn_q;
    s11.zero = (s11.mx == '0);
    s11.tir  = l_tir_q;
    s11.cos  = l_cos_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nrm_q[0] <= s11;
    end
  end

  // left-normalize so the largest magnitude has its top bit at the msb
  for (genvar j = 1; j <= drd_pkg::NormSteps; j++) begin : g_nrm
    localparam int unsigned Sh = 1 << (drd_pkg::NormSteps - j);
    nrm_t nxt;
    always_comb begin
      nxt = nrm_q[j-1];
      if (nrm_q[j-1].mx[Mw-1 -: Sh] == '0) begin
        nxt.mx = nrm_q[j-1].mx << Sh;
        for (int k = 0; k < 3; k++) begin
          nxt.mag[k] = nrm_q[j-1].mag[k] << Sh;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        nrm_q[j] <= nxt;
      end
    end
  end

  // stage m: 30-bit components and their squares
  nrm_t             s12;
  logic [59:0]      s12_sq [3];
  logic [2:0][29:0] m_m_q;
  logic [2:0][59:0] m_sq_q;
  logic [2:0]       m_sgn_q;
  logic             m_zero_q;
  logic             m_tir_q;
  logic [15:0]      m_cos_q;

  always_comb begin
    s12 = nrm_q[drd_pkg::NormSteps];
    for (int k = 0; k < 3; k++) begin
      s12_sq[k] = s12.mag[k][Mw-1:Mw-30] * s12.mag[k][Mw-1:Mw-30];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        m_m_q[k]  <= s12.mag[k][Mw-1:Mw-30];
        m_sq_q[k] <= s12_sq[k];
      end
      m_sgn_q  <= s12.sgn;
      m_zero_q <= s12.zero;
      m_tir_q  <= s12.tir;
      m_cos_q  <= s12.cos;
    end
  end

  // squared length
  sq2_t s13;
  sq2_t sq2_q [drd_pkg::Sq2Steps+1];

  always_comb begin
    s13.rem  = {2'b0, m_sq_q[0]} + {2'b0, m_sq_q[1]} + {2'b0, m_sq_q[2]};
    s13.root = '0;
    s13.m    = m_m_q;
    s13.sgn  = m_sgn_q;
    s13.zero = m_zero_q;
    s13.tir  = m_tir_q;
    s13.cos  = m_cos_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq2_q[0] <= s13;
    end
  end

  for (genvar j = 1; j <= drd_pkg::Sq2Steps; j++) begin : g_sq2
    localparam int unsigned Bi = drd_pkg::Sq2Steps - j;
    logic [63:0] trial;
    sq2_t        nxt;
    always_comb begin
      nxt   = sq2_q[j-1];
      trial = (64'(sq2_q[j-1].root) << (Bi + 1)) + (64'(1) << (2 * Bi));
      if ({2'b0, sq2_q[j-1].rem} >= trial) begin
        nxt.rem      = sq2_q[j-1].rem - trial[61:0];
        nxt.root[Bi] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq2_q[j] <= nxt;
      end
    end
  end

  // divide each component by the length, rounded half up
  sq2_t  s14;
  div2_t s14_d;
  div2_t dv2_q [drd_pkg::Div2Steps+1];

  always_comb begin
    s14 = sq2_q[drd_pkg::Sq2Steps];
    for (int k = 0; k < 3; k++) begin
      s14_d.rem[k] = {1'b0, s14.m[k], 14'b0} + {15'b0, s14.root[30:1]};
    end
    s14_d.q    = '0;
    s14_d.len  = s14.root;
    s14_d.sgn  = s14.sgn;
    s14_d.zero = s14.zero;
    s14_d.tir  = s14.tir;
    s14_d.cos  = s14.cos;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv2_q[0] <= s14_d;
    end
  end

  for (genvar j = 1; j <= drd_pkg::Div2Steps; j++) begin : g_div2
    localparam int unsigned Sh = drd_pkg::Div2Steps - j;
    logic [44:0] trial;
    div2_t       nxt;
    always_comb begin
      nxt   = dv2_q[j-1];
      trial = 45'(dv2_q[j-1].len) << Sh;
      for (int k = 0; k < 3; k++) begin
        if (dv2_q[j-1].rem[k] >= trial) begin
          nxt.rem[k]   = dv2_q[j-1].rem[k] - trial;
          nxt.q[k][Sh] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv2_q[j] <= nxt;
      end
    end
  end

  // output register
  div2_t       s15;
  logic [15:0] s15_qs [3];
  logic [15:0] s15_o [3];
  logic [15:0] o_vec_q [3];
  logic [15:0] o_cos_q;
  logic        o_tir_q;

  always_comb begin
    s15 = dv2_q[drd_pkg::Div2Steps];
    for (int k = 0; k < 3; k++) begin
      s15_qs[k] = (s15.q[k] > 15'd16384) ? 16'd16384 : {1'b0, s15.q[k]};
      if (s15.zero || s15.tir) begin
        s15_o[k] = '0;
      end else begin
        s15_o[k] = s15.sgn[k] ? 16'd0 - s15_qs[k] : s15_qs[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        o_vec_q[k] <= s15_o[k];
      end
      o_cos_q <= s15.cos;
      o_tir_q <= s15.tir;
    end
  end

  assign out_o.valid            = vld_q[Nst-1];
  assign out_o.out_x            = o_vec_q[0];
  assign out_o.out_y            = o_vec_q[1];
  assign out_o.out_z            = o_vec_q[2];
  assign out_o.cos_refracted    = o_cos_q;
  assign out_o.total_reflection = o_tir_q;

  // an accepted item shows up in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[0])
    else $error("accepted item missing from first stage");

  // ratio never exceeds 16.0 after the clamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[EStage] |-> e_r16_q <= RatioMax)
    else $error("index ratio above clamp");

  // total reflection carries all-zero results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.total_reflection |->
      out_o.out_x == '0 && out_o.out_y == '0 && out_o.out_z == '0 &&
      out_o.cos_refracted == '0)
    else $error("nonzero result on total reflection");

  // results stay within the unit range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      out_o.out_x <= 16'sd16384 && out_o.out_x >= -16'sd16384 &&
      out_o.out_y <= 16'sd16384 && out_o.out_y >= -16'sd16384 &&
      out_o.out_z <= 16'sd16384 && out_o.out_z >= -16'sd16384 &&
      out_o.cos_refracted <= 16'sd16384 && out_o.cos_refracted >= -16'sd16384)
    else $error("result out of range");

endmodule

`default_nettype wire

@@ tb/sv/dielectric_refraction_direction_tb.sv @@
`timescale 1ns / 1ps

module dielectric_refraction_direction_tb;

  localparam int unsigned VecW      = drd_pkg::VecW;
  localparam int unsigned IorW      = drd_pkg::IorW;
  localparam int unsigned AddrW     = drd_pkg::AddrW;
  localparam int unsigned DataW     = drd_pkg::DataW;
  localparam int unsigned RegSelBit = drd_pkg::RegSelBit;
  localparam int unsigned NumStages = drd_pkg::NumStages;

  typedef struct {
    logic signed [VecW-1:0] inc [3];
    logic signed [VecW-1:0] nrm [3];
  } ray_hit_t;

  typedef struct {
    logic signed [VecW-1:0] dir [3];
    logic signed [VecW-1:0] cos_t;
    logic                   tir;
  } refraction_t;

  localparam longint OneQ28   = 64'sd1 << 28;
  localparam longint DotLimit = 64'sd1 << 30;
  localparam longint RatioMax = 64'sd1 << 20;
  localparam int     Drain    = NumStages + 20;
  localparam int     MaxCycles = 1000000;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata, prdata;

  drd_in_if  in_if ();
  drd_out_if out_if ();

  dielectric_refraction_direction i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [IorW-1:0] ior_outer_q, ior_inner_q;
  refraction_t     refraction_q [$];
  int              n_errors;
  int              n_cycles;
  int              hold_cycles;
  int              ready_mode;
  int              burst_left;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > MaxCycles) begin
      $display("dielectric_refraction_direction regression: fail");
      $finish;
    end
  end

  // receiver: long hold-off takes priority over the regular stall pattern
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      case (ready_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= ((n_cycles % 16) < 5) ? 1'b0 : ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  always @(negedge clk_i) begin
    refraction_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (refraction_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = refraction_q.pop_front();
        if (out_if.out_x !== want.dir[0]) report("out_x", out_if.out_x, want.dir[0]);
        if (out_if.out_y !== want.dir[1]) report("out_y", out_if.out_y, want.dir[1]);
        if (out_if.out_z !== want.dir[2]) report("out_z", out_if.out_z, want.dir[2]);
        if (out_if.cos_refracted !== want.cos_t)
          report("cos_refracted", out_if.cos_refracted, want.cos_t);
        if (out_if.total_reflection !== want.tir)
          report("total_reflection", out_if.total_reflection, want.tir);
      end
    end
  end

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [VecW-1:0] clamp_q14(longint v);
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v[VecW-1:0];
  endfunction

  function automatic refraction_t refract(ray_hit_t h);
    refraction_t     o;
    longint          iv [3], nv [3], d, om, r2, s, r16, c14, rd, root28, nf, v;
    longint unsigned num, den, dmag, root21, mx, len2, len, q;
    longint unsigned mag [3];
    logic            sgn [3];
    logic            neg;
    int              down, up;
    for (int k = 0; k < 3; k++) begin
      iv[k] = h.inc[k];
      nv[k] = h.nrm[k];
      o.dir[k] = '0;
    end
    o.cos_t = '0;
    o.tir = 1'b0;
    d = iv[0] * nv[0] + iv[1] * nv[1] + iv[2] * nv[2];
    if (d > DotLimit) d = DotLimit;
    if (d < -DotLimit) d = -DotLimit;
    neg = d < 0;
    num = neg ? ior_inner_q : ior_outer_q;
    den = neg ? ior_outer_q : ior_inner_q;
    if (den == 0) den = 1;
    r16 = longint'((num << 16) / den);
    if (r16 > RatioMax) r16 = RatioMax;
    dmag = neg ? -d : d;
    om = OneQ28 - longint'((dmag * dmag) >> 28);
    r2 = (r16 * r16) >>> 16;
    s = OneQ28 - ((r2 * om) >>> 16);
    if (s <= 0) begin
      o.tir = 1'b1;
      return o;
    end
    root21 = floor_sqrt(longint'(s) << 14);
    c14 = longint'((root21 + 64) >> 7);
    o.cos_t = clamp_q14(neg ? c14 : -c14);
    rd = (r16 * d) >>> 16;
    root28 = longint'(root21 << 7);
    nf = neg ? rd + root28 : rd - root28;
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      v = nv[k] * nf - iv[k] * r16 * 4096;
      sgn[k] = v < 0;
      mag[k] = v < 0 ? -v : v;
      if (mag[k] > mx) mx = mag[k];
    end
    if (mx == 0) return o;
    down = 0;
    while ((mx >> down) >= (64'd1 << 30)) down++;
    up = 0;
    while (down == 0 && (mx << up) < (64'd1 << 29)) up++;
    len2 = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (mag[k] >> down) << up;
      len2 += mag[k] * mag[k];
    end
    len = floor_sqrt(len2);
    if (len == 0) return o;
    for (int k = 0; k < 3; k++) begin
      q = ((mag[k] << 14) + (len >> 1)) / len;
      o.dir[k] = clamp_q14(sgn[k] ? -longint'(q) : longint'(q));
    end
    return o;
  endfunction

  // offers one item, leaving valid high for the next one of the burst
  task automatic send_hit(ray_hit_t h);
    logic taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid  <= 1'b1;
    in_if.inc_x  <= h.inc[0];
    in_if.inc_y  <= h.inc[1];
    in_if.inc_z  <= h.inc[2];
    in_if.norm_x <= h.nrm[0];
    in_if.norm_y <= h.nrm[1];
    in_if.norm_z <= h.nrm[2];
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_if.ready;
      @(posedge clk_i);
    end
    refraction_q.push_back(refract(h));
  endtask

  task automatic write_ior(drd_pkg::reg_idx_e idx, logic [IorW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx) << RegSelBit;
    pwdata  <= DataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == drd_pkg::REG_IOR_OUTER) ior_outer_q = value;
    else ior_inner_q = value;
    // bus idle between transfers
    @(posedge clk_i);
  endtask

  task automatic drain_pipe();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (refraction_q.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic set_iors(logic [IorW-1:0] outer, logic [IorW-1:0] inner);
    drain_pipe();
    write_ior(drd_pkg::REG_IOR_OUTER, outer);
    write_ior(drd_pkg::REG_IOR_INNER, inner);
  endtask

  function automatic ray_hit_t make_hit(int ix, int iy, int iz, int nx, int ny, int nz);
    ray_hit_t h;
    h.inc[0] = VecW'(ix); h.inc[1] = VecW'(iy); h.inc[2] = VecW'(iz);
    h.nrm[0] = VecW'(nx); h.nrm[1] = VecW'(ny); h.nrm[2] = VecW'(nz);
    return h;
  endfunction

  function automatic void unit_vec(output logic signed [VecW-1:0] u [3]);
    real c [3];
    real n;
    n = 0.0;
    while (n < 1.0) begin
      for (int k = 0; k < 3; k++) c[k] = $itor($urandom_range(0, 2000)) - 1000.0;
      n = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2]);
    end
    for (int k = 0; k < 3; k++) u[k] = VecW'($rtoi(c[k] / n * 16384.0));
  endfunction

  function automatic ray_hit_t random_hit();
    ray_hit_t h;
    // mostly unit directions, the rest arbitrary in-range noise
    if ($urandom_range(0, 4) != 0) begin
      unit_vec(h.inc);
      unit_vec(h.nrm);
    end else begin
      for (int k = 0; k < 3; k++) begin
        h.inc[k] = VecW'($urandom_range(0, 32768) - 16384);
        h.nrm[k] = VecW'($urandom_range(0, 32768) - 16384);
      end
    end
    return h;
  endfunction

  task automatic test_directed();
    ready_mode = 1;
    send_hit(make_hit(0, 0, -16384, 0, 0, 16384));        // head-on from outside
    send_hit(make_hit(0, 0, 16384, 0, 0, 16384));         // head-on from inside
    send_hit(make_hit(16384, 0, 0, 0, 0, 16384));         // grazing, dot is zero
    send_hit(make_hit(16000, 0, -3000, 0, 0, 16384));     // shallow entry: total reflection
    send_hit(make_hit(0, 0, 0, 0, 0, 0));                 // zero-length refracted vector
    send_hit(make_hit(16384, 16384, 16384, 16384, 16384, 16384));
    send_hit(make_hit(-16384, -16384, -16384, 16384, 16384, 16384));
    send_hit(make_hit(-16384, 16384, -16384, -16384, 16384, -16384));
    send_hit(make_hit(11585, 0, -11585, 0, 0, 16384));    // 45 degree entry
    send_hit(make_hit(11585, 0, 11585, 0, 0, 16384));     // 45 degree exit
    send_hit(make_hit(1, -1, 1, -1, 1, -1));
    send_hit(make_hit(0, 16384, 0, 0, -16384, 0));
    send_hit(make_hit(16384, 0, 0, 16384, 0, 0));
    set_iors(16'd65535, 16'd4096);                        // largest ratio one way
    send_hit(make_hit(0, 11585, -11585, 0, 0, 16384));
    send_hit(make_hit(0, 11585, 11585, 0, 0, 16384));
    send_hit(make_hit(0, 0, 0, 0, 0, 0));
    set_iors(16'd4096, 16'd65535);
    send_hit(make_hit(0, 11585, -11585, 0, 0, 16384));
    send_hit(make_hit(0, 11585, 11585, 0, 0, 16384));
    send_hit(make_hit(-16384, 0, 0, 0, 0, -16384));
  endtask

  task automatic test_random_iors();
    logic [IorW-1:0] settings [6][2];
    settings = '{'{16'd4096, 16'd6144}, '{16'd65535, 16'd65535}, '{16'd4096, 16'd4096},
                 '{16'd6144, 16'd4096}, '{16'd65535, 16'd4096}, '{16'd4096, 16'd65535}};
    for (int p = 0; p < 8; p++) begin
      if (p < 6) set_iors(settings[p][0], settings[p][1]);
      else set_iors(IorW'($urandom_range(4096, 65535)), IorW'($urandom_range(4096, 65535)));
      ready_mode = p % 3;
      repeat (80) send_hit(random_hit());
    end
  endtask

  task automatic test_backpressure();
    set_iors(16'd4096, 16'd6144);
    ready_mode = 1;
    hold_cycles = 4 * NumStages;
    repeat (250) send_hit(random_hit());
  endtask

  initial begin
    n_errors = 0;
    n_cycles = 0;
    hold_cycles = 0;
    ready_mode = 0;
    burst_left = 0;
    ior_outer_q = drd_pkg::IorOuterRst;
    ior_inner_q = drd_pkg::IorInnerRst;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.inc_x = '0;
    in_if.inc_y = '0;
    in_if.inc_z = '0;
    in_if.norm_x = '0;
    in_if.norm_y = '0;
    in_if.norm_z = '0;
    out_if.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_iors();
    test_backpressure();
    drain_pipe();
    if (n_errors == 0) begin
      $display("dielectric_refraction_direction regression: pass");
    end else begin
      $display("dielectric_refraction_direction regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/drd_pkg.sv
src/drd_if.sv
src/dielectric_refraction_direction.sv
tb/sv/dielectric_refraction_direction_tb.sv
